[rtl/prld_pkg.sv]
`timescale 1ns / 1ps
package prld_pkg;

  localparam int unsigned PIXEL_COUNT_BITS_DEF = 24;
  localparam int unsigned PIXEL_TOTAL_W        = 24;
  localparam int unsigned PIXEL_W              = 24;
  localparam int unsigned COUNT_W              = 8;
  localparam int unsigned BYTE_W               = 8;
  localparam int unsigned CFG_IDX_W            = 1;
  localparam int unsigned CFG_DATA_W           = 24;
  localparam int unsigned OUT_TDATA_W          = PIXEL_W + COUNT_W;

  localparam logic [BYTE_W-1:0]    LITERAL_BASE  = 8'd128;
  localparam logic [COUNT_W-1:0]   MAX_REPEAT    = 8'd128;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL = 1'd1;

endpackage

[rtl/pixel_run_length_decoder.sv]
`timescale 1ns / 1ps
// A result is written to the output register at the byte transfer and appears in the cycle after it.
// Throughput: one compressed byte per cycle; the byte path and the output register
// are parted, so a byte is taken while a result waits as long as it is taken alongside.
// s_axis_tready is low only while a held result is stalled by m_axis_tready.
// Reset (rst_ni low, asynchronous) clears the registers, run state and pixel count.
module pixel_run_length_decoder import prld_pkg::*; #(
  parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic                    s_axis_tuser,   // [0] start_of_image
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [23:0] pixel_value, [31:24] repeat_count
  output logic                    m_axis_tlast    // image_done
);

  localparam int unsigned PCB = PIXEL_COUNT_BITS;
  localparam int unsigned CW  = (PCB > PIXEL_TOTAL_W) ? PCB : PIXEL_TOTAL_W;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  logic                     mode_q;
  logic [PIXEL_TOTAL_W-1:0] total_q;

  phase_e                   phase_q, phase_c, phase_d;
  logic [COUNT_W-1:0]       remain_q, remain_c, remain_d;
  logic [COUNT_W-1:0]       replen_q, replen_c, replen_d;
  logic [1:0]               bip_q, bip_c, bip_d;
  logic [PIXEL_W-1:0]       asm_q, asm_c, asm_d;
  logic [PCB-1:0]           done_q, done_c, done_d;

  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;
  logic                     out_last_q;

  logic [CW-1:0]            tot_ext, mask_ext;
  logic [PCB-1:0]           tot, left;
  logic [COUNT_W-1:0]       count;
  logic [2:0]               need, bip_inc;
  logic                     res_valid, res_last, accept;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign tot_ext  = CW'(total_q);
  assign mask_ext = CW'({PCB{1'b1}});
  assign tot      = (tot_ext > mask_ext) ? PCB'(mask_ext) : PCB'(tot_ext);

  always_comb begin
    if (s_axis_tuser) begin
      phase_c  = PH_CONTROL;
      remain_c = '0;
      replen_c = '0;
      bip_c    = '0;
      asm_c    = '0;
      done_c   = '0;
    end else begin
      phase_c  = phase_q;
      remain_c = remain_q;
      replen_c = replen_q;
      bip_c    = bip_q;
      asm_c    = asm_q;
      done_c   = done_q;
    end

    phase_d   = phase_c;
    remain_d  = remain_c;
    replen_d  = replen_c;
    bip_d     = bip_c;
    asm_d     = asm_c;
    done_d    = done_c;
    res_valid = 1'b0;
    res_last  = 1'b0;
    count     = '0;
    left      = tot - done_c;
    need      = mode_q ? 3'd3 : 3'd1;
    bip_inc   = {1'b0, bip_c} + 3'd1;

    if (done_c < tot) begin
      unique case (phase_c)
        PH_LITERAL, PH_REPEAT: begin
          asm_d = (bip_c == 2'd0) ? PIXEL_W'(s_axis_tdata)
                                  : {asm_c[PIXEL_W-BYTE_W-1:0], s_axis_tdata};
          if (bip_inc < need) begin
            bip_d = bip_inc[1:0];
          end else begin
            bip_d = '0;
            if (phase_c == PH_LITERAL) begin
              count    = COUNT_W'(1);
              remain_d = remain_c - COUNT_W'(1);
              if (remain_d == '0) begin
                phase_d = PH_CONTROL;
              end
            end else begin
              count   = (PCB'(replen_c) > left) ? left[COUNT_W-1:0] : replen_c;
              phase_d = PH_CONTROL;
            end
            done_d    = done_c + PCB'(count);
            res_valid = 1'b1;
            res_last  = (done_d == tot);
          end
        end
        default: begin
          if (s_axis_tdata >= LITERAL_BASE) begin
            remain_d = s_axis_tdata - LITERAL_BASE;
            phase_d  = (remain_d != '0) ? PH_LITERAL : PH_CONTROL;
          end else begin
            replen_d = s_axis_tdata + COUNT_W'(1);
            phase_d  = PH_REPEAT;
          end
          bip_d = '0;
          asm_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      total_q     <= '0;
      phase_q     <= PH_CONTROL;
      remain_q    <= '0;
      replen_q    <= '0;
      bip_q       <= '0;
      asm_q       <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PIXEL_MODE) begin
          mode_q <= cfg_data_i[0];
        end else if (cfg_idx_i == REG_PIXEL_TOTAL) begin
          total_q <= cfg_data_i[PIXEL_TOTAL_W-1:0];
        end
      end
      if (accept) begin
        phase_q  <= phase_d;
        remain_q <= remain_d;
        replen_q <= replen_d;
        bip_q    <= bip_d;
        asm_q    <= asm_d;
        done_q   <= done_d;
      end
      if (accept && res_valid) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {count, asm_d};
        out_last_q  <= res_last;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/prld_checker.sv]
`timescale 1ns / 1ps
module prld_checker import prld_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_xfer;
  logic m_stall;

  assign s_xfer  = s_axis_tvalid & s_axis_tready;
  assign m_stall = m_axis_tvalid & ~m_axis_tready;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:PIXEL_W] != '0) &&
                      (m_axis_tdata[OUT_TDATA_W-1:PIXEL_W] <= MAX_REPEAT))
    else $error("repeat count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tuser && !m_stall |=> !m_axis_tvalid)
    else $error("result from start-of-image byte");

  a_result_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_stall && !s_xfer |=> !m_axis_tvalid)
    else $error("result without a byte transfer");

endmodule

bind pixel_run_length_decoder prld_checker u_prld_checker (.*);
